// ----- rtl/assert_macros.svh -----
// assertion helpers for the voxel face block
// both expect clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define VFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define VFV_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/vfv_pkg.sv -----
package vfv_pkg;

  // coordinate fields as carried on the ports
  localparam int X_W = 5;
  localparam int Y_W = 5;
  localparam int Z_W = 6;
  localparam int FIELD_X = 32;
  localparam int FIELD_Y = 32;
  localparam int FIELD_Z = 64;

  // occupancy store covers every addressable cell
  localparam int ADDR_W = X_W + Y_W + Z_W;

  // neighbor coordinates: room for grid edges up to 511 and for wrap below zero
  localparam int COORD_W = 9;

  // default grid size
  localparam int GRID_X_DEF = 32;
  localparam int GRID_Y_DEF = 32;
  localparam int GRID_Z_DEF = 64;

  localparam int FACE_W = 6;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } state_t;

  // read order of one query: the cell itself, then its six neighbors
  typedef enum logic [2:0] {
    STEP_CENTER = 3'd0,
    STEP_ZP     = 3'd1,
    STEP_ZN     = 3'd2,
    STEP_YP     = 3'd3,
    STEP_YN     = 3'd4,
    STEP_XP     = 3'd5,
    STEP_XN     = 3'd6
  } step_t;

  // face bit positions in face_mask
  localparam int FACE_ZP = 0;
  localparam int FACE_ZN = 1;
  localparam int FACE_YP = 2;
  localparam int FACE_YN = 3;
  localparam int FACE_XP = 4;
  localparam int FACE_XN = 5;

  // linear address of an addressable cell
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y,
                                                  input logic [Z_W-1:0] z);
    cell_addr = {x, y, z};
  endfunction

endpackage

// ----- rtl/vfv_occ_mem.sv -----
module vfv_occ_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [vfv_pkg::ADDR_W-1:0] wr_addr,
  input  logic                      wr_data,
  input  logic                      rd_en,
  input  logic [vfv_pkg::ADDR_W-1:0] rd_addr,
  output logic                      rd_data
);

  localparam int DEPTH = 1 << vfv_pkg::ADDR_W;

  logic mem [DEPTH];
  logic rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/voxel_face_visibility.sv -----
// query: busy for the read and wait states; the next item may come while the result strobe shows
// write: no result and no busy state; a new item may follow at the next edge
// rate is set by the single read port of the occupancy memory: seven reads per query
// reset clears the sequencer and result strobe; occupancy contents are kept
// out_valid is a one-cycle strobe, the receiver cannot stall
`include "assert_macros.svh"

module voxel_face_visibility #(
  parameter int GRID_X = vfv_pkg::GRID_X_DEF,
  parameter int GRID_Y = vfv_pkg::GRID_Y_DEF,
  parameter int GRID_Z = vfv_pkg::GRID_Z_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [vfv_pkg::X_W-1:0]       in_cell_x,
  input  logic [vfv_pkg::Y_W-1:0]       in_cell_y,
  input  logic [vfv_pkg::Z_W-1:0]       in_cell_z,
  input  logic                          in_solid,
  output logic                          out_valid,
  output logic [vfv_pkg::FACE_W-1:0]    out_face_mask
);

  localparam int CW = vfv_pkg::COORD_W;
  localparam logic [CW-1:0] LIM_X = CW'(GRID_X);
  localparam logic [CW-1:0] LIM_Y = CW'(GRID_Y);
  localparam logic [CW-1:0] LIM_Z = CW'(GRID_Z);
  localparam logic [CW-1:0] FLD_X = CW'(vfv_pkg::FIELD_X);
  localparam logic [CW-1:0] FLD_Y = CW'(vfv_pkg::FIELD_Y);
  localparam logic [CW-1:0] FLD_Z = CW'(vfv_pkg::FIELD_Z);
  localparam logic [CW-1:0] ONE   = CW'(1);

  vfv_pkg::state_t state_r, state_nxt;
  vfv_pkg::step_t  step_r, step_nxt;
  vfv_pkg::step_t  rd_step_r, rd_step_nxt;
  logic [vfv_pkg::X_W-1:0] x_r, x_nxt;
  logic [vfv_pkg::Y_W-1:0] y_r, y_nxt;
  logic [vfv_pkg::Z_W-1:0] z_r, z_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic rd_ok_r, rd_ok_nxt;
  logic center_solid_r, center_solid_nxt;
  logic [vfv_pkg::FACE_W-1:0] faces_r, faces_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [vfv_pkg::FACE_W-1:0] out_face_mask_r, out_face_mask_nxt;

  logic accept;
  logic wr_en;
  logic wr_in_grid;
  logic rd_en;
  logic rd_data;
  logic [CW-1:0] nx, ny, nz;
  logic nb_ok;
  logic [vfv_pkg::ADDR_W-1:0] rd_addr;
  logic [vfv_pkg::ADDR_W-1:0] wr_addr;

  assign busy   = (state_r != vfv_pkg::ST_IDLE);
  assign accept = start && !busy;

  // writes go straight to the store when the cell lies in the grid
  assign wr_in_grid = ({{(CW-vfv_pkg::X_W){1'b0}}, in_cell_x} < LIM_X) &&
                      ({{(CW-vfv_pkg::Y_W){1'b0}}, in_cell_y} < LIM_Y) &&
                      ({{(CW-vfv_pkg::Z_W){1'b0}}, in_cell_z} < LIM_Z);
  assign wr_en   = accept && (in_action == vfv_pkg::ACT_WRITE) && wr_in_grid;
  assign wr_addr = vfv_pkg::cell_addr(in_cell_x, in_cell_y, in_cell_z);

  // neighbor coordinate of the current read step; below zero wraps high
  always_comb begin
    nx = {{(CW-vfv_pkg::X_W){1'b0}}, x_r};
    ny = {{(CW-vfv_pkg::Y_W){1'b0}}, y_r};
    nz = {{(CW-vfv_pkg::Z_W){1'b0}}, z_r};
    unique case (step_r)
      vfv_pkg::STEP_CENTER: ;
      vfv_pkg::STEP_ZP: nz = nz + ONE;
      vfv_pkg::STEP_ZN: nz = nz - ONE;
      vfv_pkg::STEP_YP: ny = ny + ONE;
      vfv_pkg::STEP_YN: ny = ny - ONE;
      vfv_pkg::STEP_XP: nx = nx + ONE;
      vfv_pkg::STEP_XN: nx = nx - ONE;
      default: ;
    endcase
  end

  // the cell counts only if inside the grid and addressable; else it reads as air
  assign nb_ok = (nx < LIM_X) && (ny < LIM_Y) && (nz < LIM_Z) &&
                 (nx < FLD_X) && (ny < FLD_Y) && (nz < FLD_Z);
  assign rd_addr = vfv_pkg::cell_addr(nx[vfv_pkg::X_W-1:0], ny[vfv_pkg::Y_W-1:0],
                                      nz[vfv_pkg::Z_W-1:0]);
  assign rd_en = (state_r == vfv_pkg::ST_READ);

  vfv_occ_mem u_occ (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_solid),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: issue seven reads, fold each neighbor bit into the mask and keep the center bit as its gate
  always_comb begin
    state_nxt         = state_r;
    step_nxt          = step_r;
    x_nxt             = x_r;
    y_nxt             = y_r;
    z_nxt             = z_r;
    rd_pend_nxt       = 1'b0;
    rd_step_nxt       = step_r;
    rd_ok_nxt         = nb_ok;
    center_solid_nxt  = center_solid_r;
    faces_nxt         = faces_r;
    out_valid_nxt     = 1'b0;
    out_face_mask_nxt = out_face_mask_r;

    unique case (state_r)
      vfv_pkg::ST_IDLE: begin
        if (accept && (in_action == vfv_pkg::ACT_QUERY)) begin
          x_nxt     = in_cell_x;
          y_nxt     = in_cell_y;
          z_nxt     = in_cell_z;
          step_nxt  = vfv_pkg::STEP_CENTER;
          state_nxt = vfv_pkg::ST_READ;
        end
      end
      vfv_pkg::ST_READ: begin
        rd_pend_nxt = 1'b1;
        if (step_r == vfv_pkg::STEP_XN) begin
          state_nxt = vfv_pkg::ST_WAIT;
        end else begin
          step_nxt = vfv_pkg::step_t'(step_r + 3'd1);
        end
      end
      vfv_pkg::ST_WAIT: begin
        state_nxt = vfv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = vfv_pkg::ST_IDLE;
      end
    endcase

    // collect the bit read in the previous cycle
    if (rd_pend_r) begin
      unique case (rd_step_r)
        vfv_pkg::STEP_CENTER: center_solid_nxt = rd_ok_r && rd_data;
        vfv_pkg::STEP_ZP: faces_nxt[vfv_pkg::FACE_ZP] = !(rd_ok_r && rd_data);
        vfv_pkg::STEP_ZN: faces_nxt[vfv_pkg::FACE_ZN] = !(rd_ok_r && rd_data);
        vfv_pkg::STEP_YP: faces_nxt[vfv_pkg::FACE_YP] = !(rd_ok_r && rd_data);
        vfv_pkg::STEP_YN: faces_nxt[vfv_pkg::FACE_YN] = !(rd_ok_r && rd_data);
        vfv_pkg::STEP_XP: faces_nxt[vfv_pkg::FACE_XP] = !(rd_ok_r && rd_data);
        vfv_pkg::STEP_XN: faces_nxt[vfv_pkg::FACE_XN] = !(rd_ok_r && rd_data);
        default: ;
      endcase
      if (rd_step_r == vfv_pkg::STEP_XN) begin
        out_valid_nxt     = 1'b1;
        out_face_mask_nxt = center_solid_r ? faces_nxt : '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfv_pkg::ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    step_r          <= step_nxt;
    rd_step_r       <= rd_step_nxt;
    x_r             <= x_nxt;
    y_r             <= y_nxt;
    z_r             <= z_nxt;
    rd_ok_r         <= rd_ok_nxt;
    center_solid_r  <= center_solid_nxt;
    faces_r         <= faces_nxt;
    out_face_mask_r <= out_face_mask_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_face_mask = out_face_mask_r;

  // checks
  `VFV_ASSERT(a_query_goes_busy, (accept && (in_action == vfv_pkg::ACT_QUERY)) |=> busy, "query accepted but block not busy")
  `VFV_ASSERT(a_result_after_wait, out_valid |-> $past(state_r == vfv_pkg::ST_WAIT), "result strobe without finished read sequence")
  `VFV_IMPLY(a_no_write_while_busy, wr_en, state_r == vfv_pkg::ST_IDLE, "store written during a query")
  `VFV_IMPLY(a_air_center_no_faces, out_valid && (out_face_mask != '0), center_solid_r, "faces reported for an air cell")

endmodule

// ----- tb/voxel_face_visibility_tb.sv -----
`timescale 1ns / 100ps

module voxel_face_visibility_tb;

  localparam int GRID_X = vfv_pkg::GRID_X_DEF;
  localparam int GRID_Y = vfv_pkg::GRID_Y_DEF;
  localparam int GRID_Z = vfv_pkg::GRID_Z_DEF;
  localparam int CELL_COUNT = 1 << vfv_pkg::ADDR_W;
  localparam int RANDOM_BEATS = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    vfv_pkg::action_t           act;
    int                         x;
    int                         y;
    int                         z;
    bit                         solid;
    bit                         has_exp;
    logic [vfv_pkg::FACE_W-1:0] exp_mask;
  } beat_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_action = 1'b0;
  logic [vfv_pkg::X_W-1:0]    in_cell_x = '0;
  logic [vfv_pkg::Y_W-1:0]    in_cell_y = '0;
  logic [vfv_pkg::Z_W-1:0]    in_cell_z = '0;
  logic                       in_solid = 1'b0;
  logic                       out_valid;
  logic [vfv_pkg::FACE_W-1:0] out_face_mask;

  // mirror of the occupancy store
  bit                         occ_mirror [0:CELL_COUNT-1];
  logic [vfv_pkg::FACE_W-1:0] pending_masks [$];
  int                         queried_cells [$];
  logic [vfv_pkg::FACE_W-1:0] expected_mask;
  beat_row_t                  directed_rows [23];

  int failures = 0;
  int n_writes = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_random = 0;
  int cycle_count = 0;
  bit burst_mode = 1'b0;

  voxel_face_visibility u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_z     (in_cell_z),
    .in_solid      (in_solid),
    .out_valid     (out_valid),
    .out_face_mask (out_face_mask)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y && z >= 0 && z < GRID_Z;
  endfunction

  function automatic bit addressable(int x, int y, int z);
    return x >= 0 && x < vfv_pkg::FIELD_X && y >= 0 && y < vfv_pkg::FIELD_Y &&
           z >= 0 && z < vfv_pkg::FIELD_Z;
  endfunction

  function automatic int addr_of(int x, int y, int z);
    return (x * vfv_pkg::FIELD_Y + y) * vfv_pkg::FIELD_Z + z;
  endfunction

  // cells the ports cannot reach read as air
  function automatic bit solid_at(int x, int y, int z);
    if (!addressable(x, y, z)) return 1'b0;
    return occ_mirror[addr_of(x, y, z)];
  endfunction

  // move one step across the given face
  function automatic void step_across(int face, inout int x, inout int y, inout int z);
    case (face)
      vfv_pkg::FACE_ZP: z = z + 1;
      vfv_pkg::FACE_ZN: z = z - 1;
      vfv_pkg::FACE_YP: y = y + 1;
      vfv_pkg::FACE_YN: y = y - 1;
      vfv_pkg::FACE_XP: x = x + 1;
      default: x = x - 1;
    endcase
  endfunction

  // faces to draw: solid cell, neighbor is air or off the grid
  function automatic logic [vfv_pkg::FACE_W-1:0] visible_faces(int x, int y, int z);
    logic [vfv_pkg::FACE_W-1:0] m;
    int nx, ny, nz;
    m = '0;
    if (in_grid(x, y, z) && solid_at(x, y, z)) begin
      for (int f = 0; f < vfv_pkg::FACE_W; f++) begin
        nx = x;
        ny = y;
        nz = z;
        step_across(f, nx, ny, nz);
        m[f] = !in_grid(nx, ny, nz) || !solid_at(nx, ny, nz);
      end
    end
    return m;
  endfunction

  // most coordinates random, a good share pinned to the grid edges
  function automatic int edge_biased(int maxv);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 4) return maxv;
    return $urandom_range(0, maxv);
  endfunction

  // present one beat with a random lead-in gap and hold it until taken
  task automatic drive_beat(vfv_pkg::action_t act, int x, int y, int z, bit solid,
                            bit has_exp, logic [vfv_pkg::FACE_W-1:0] exp_mask);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) gap = 0;
    else if (r < 94) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action <= act;
    in_cell_x <= x[vfv_pkg::X_W-1:0];
    in_cell_y <= y[vfv_pkg::Y_W-1:0];
    in_cell_z <= z[vfv_pkg::Z_W-1:0];
    in_solid  <= solid;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    // beat taken: update the mirror or queue the face mask
    if (act == vfv_pkg::ACT_WRITE) begin
      if (in_grid(x, y, z) && addressable(x, y, z)) begin
        occ_mirror[addr_of(x, y, z)] = solid;
      end
      n_writes++;
    end else begin
      pending_masks = {pending_masks, has_exp ? exp_mask : visible_faces(x, y, z)};
      n_queries++;
    end
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_masks.size() == 0) begin
        $error("face_mask result with nothing expected: actual %0d", out_face_mask);
        failures++;
      end else begin
        expected_mask = pending_masks.pop_front();
        if (out_face_mask !== expected_mask) begin
          $error("face_mask mismatch: expected %0d, actual %0d", expected_mask, out_face_mask);
          failures++;
        end
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d face masks outstanding",
               cycle_count, pending_masks.size());
      $display("[voxel_face_visibility] ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    int cx, cy, cz;
    int nx, ny, nz;
    int pick;
    int a;

    // directed beats: grid corners, all faces open, overwrites, air cells
    directed_rows = '{
      '{vfv_pkg::ACT_WRITE,  0,  0,  0, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE,  0,  0,  1, 1'b0, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE,  0,  1,  0, 1'b0, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE,  1,  0,  0, 1'b0, 1'b0, 6'd0},
      '{vfv_pkg::ACT_QUERY,  0,  0,  0, 1'b0, 1'b1, 6'd63},
      '{vfv_pkg::ACT_WRITE,  0,  0,  1, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE,  0,  1,  0, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE,  1,  0,  0, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_QUERY,  0,  0,  0, 1'b1, 1'b1, 6'd42},
      '{vfv_pkg::ACT_WRITE,  0,  0,  0, 1'b0, 1'b0, 6'd0},
      '{vfv_pkg::ACT_QUERY,  0,  0,  0, 1'b0, 1'b1, 6'd0},
      '{vfv_pkg::ACT_WRITE, 31, 31, 63, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE, 31, 31, 62, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE, 31, 30, 63, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE, 30, 31, 63, 1'b0, 1'b0, 6'd0},
      '{vfv_pkg::ACT_QUERY, 31, 31, 63, 1'b0, 1'b1, 6'd53},
      '{vfv_pkg::ACT_WRITE, 29, 31, 63, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE, 30, 30, 63, 1'b0, 1'b0, 6'd0},
      '{vfv_pkg::ACT_WRITE, 30, 31, 62, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_QUERY, 30, 31, 63, 1'b1, 1'b1, 6'd0},
      '{vfv_pkg::ACT_QUERY, 31, 31, 63, 1'b1, 1'b1, 6'd53},
      '{vfv_pkg::ACT_WRITE, 30, 31, 63, 1'b1, 1'b0, 6'd0},
      '{vfv_pkg::ACT_QUERY, 31, 31, 63, 1'b0, 1'b0, 6'd0}
    };

    // hold synchronous reset, then release it at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      drive_beat(directed_rows[i].act, directed_rows[i].x, directed_rows[i].y,
                 directed_rows[i].z, directed_rows[i].solid, directed_rows[i].has_exp,
                 directed_rows[i].exp_mask);
    end
    for (int i = 0; i < 3; i++) begin
      queried_cells = {queried_cells, addr_of(0, 0, 0)};
    end
    queried_cells = {queried_cells, addr_of(31, 31, 63)};
    queried_cells = {queried_cells, addr_of(30, 31, 63)};

    // random part: mostly neighborhoods written then queried
    while (n_random < RANDOM_BEATS) begin
      if ($urandom_range(0, 7) == 0) burst_mode = ~burst_mode;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // dense corner box so clusters overlap, else anywhere with edge bias
        if ($urandom_range(0, 2) == 0) begin
          cx = $urandom_range(0, 3);
          cy = $urandom_range(0, 3);
          cz = $urandom_range(0, 3);
        end else begin
          cx = edge_biased(vfv_pkg::FIELD_X - 1);
          cy = edge_biased(vfv_pkg::FIELD_Y - 1);
          cz = edge_biased(vfv_pkg::FIELD_Z - 1);
        end
        for (int f = 0; f < vfv_pkg::FACE_W; f++) begin
          nx = cx;
          ny = cy;
          nz = cz;
          step_across(f, nx, ny, nz);
          if (in_grid(nx, ny, nz) && addressable(nx, ny, nz)) begin
            drive_beat(vfv_pkg::ACT_WRITE, nx, ny, nz, 1'($urandom_range(0, 1)), 1'b0, '0);
            n_random++;
          end
        end
        drive_beat(vfv_pkg::ACT_WRITE, cx, cy, cz, $urandom_range(0, 3) != 0, 1'b0, '0);
        drive_beat(vfv_pkg::ACT_QUERY, cx, cy, cz, 1'($urandom_range(0, 1)), 1'b0, '0);
        n_random += 2;
        queried_cells = {queried_cells, addr_of(cx, cy, cz)};
      end else if (r < 85) begin
        // re-query a cell whose whole neighborhood is known
        pick = $urandom_range(0, queried_cells.size() - 1);
        a = queried_cells[pick];
        cz = a % vfv_pkg::FIELD_Z;
        cy = (a / vfv_pkg::FIELD_Z) % vfv_pkg::FIELD_Y;
        cx = a / (vfv_pkg::FIELD_Z * vfv_pkg::FIELD_Y);
        drive_beat(vfv_pkg::ACT_QUERY, cx, cy, cz, 1'($urandom_range(0, 1)), 1'b0, '0);
        n_random++;
      end else begin
        // stray write anywhere
        drive_beat(vfv_pkg::ACT_WRITE, $urandom_range(0, vfv_pkg::FIELD_X - 1),
                   $urandom_range(0, vfv_pkg::FIELD_Y - 1),
                   $urandom_range(0, vfv_pkg::FIELD_Z - 1), 1'($urandom_range(0, 1)),
                   1'b0, '0);
        n_random++;
      end
    end

    // drain outstanding results
    start <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d cell writes and %0d face queries, %0d masks compared",
             n_writes, n_queries, n_checked);
    $display("grid corners, edge cells, air cells and overwritten neighbors included");
    if (failures == 0) begin
      $display("[voxel_face_visibility] OK");
    end else begin
      $display("[voxel_face_visibility] ERROR");
    end
    $finish;
  end

endmodule

// ----- voxel_face_visibility.f -----
+incdir+rtl
rtl/vfv_pkg.sv
rtl/vfv_occ_mem.sv
rtl/voxel_face_visibility.sv
tb/voxel_face_visibility_tb.sv
